// ===== design/vnf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnf_pkg
// Shared types and constants for the 3D vector normalizer.
// ----------------------------------------------------------------------------
package vnf_pkg;

    localparam int unsigned DW        = 32;
    localparam int unsigned SQW       = 64;
    localparam int unsigned SQ_STEPS  = 32;
    localparam int unsigned REM_W     = 34;
    localparam int unsigned Q_BITS    = 17;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned NCOMP     = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOLERANCE  = 2'd0,
        CFG_FALLBACK_X = 2'd1,
        CFG_FALLBACK_Y = 2'd2,
        CFG_FALLBACK_Z = 2'd3
    } cfg_idx_t;

    typedef logic [DW-1:0] word_t;

endpackage

// ===== design/vector3_normalize_with_fallback.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_normalize_with_fallback
// Q16.16 vector normalizer: squares, 32-stage square root, 17-stage dividers,
// fallback vector when the length is at or below the tolerance.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; the whole pipeline stalls together
// only when the output register holds a result that is not taken.
// Depth is set by the one-bit-per-stage square root and divider chains.
// Reset: rst_n async low clears valid bits and config registers to zero.
module vector3_normalize_with_fallback
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [vnf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vnf_pkg::DW-1:0]        cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [vnf_pkg::DW-1:0] vec_x,
    input  logic signed [vnf_pkg::DW-1:0] vec_y,
    input  logic signed [vnf_pkg::DW-1:0] vec_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [vnf_pkg::DW-1:0] unit_x,
    output logic signed [vnf_pkg::DW-1:0] unit_y,
    output logic signed [vnf_pkg::DW-1:0] unit_z,
    output logic [vnf_pkg::DW-1:0]        vector_length,
    output logic                          used_fallback
);
    import vnf_pkg::*;

    logic adv;

    word_t tol_reg, fbx_reg, fby_reg, fbz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= '0;
            fbx_reg <= '0;
            fby_reg <= '0;
            fbz_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TOLERANCE:  tol_reg <= cfg_data;
                CFG_FALLBACK_X: fbx_reg <= cfg_data;
                CFG_FALLBACK_Y: fby_reg <= cfg_data;
                CFG_FALLBACK_Z: fbz_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage A: magnitudes
    logic           a_v_reg;
    word_t          a_mag_reg [NCOMP];
    logic [NCOMP-1:0] a_sgn_reg;
    // stage B: squares
    logic           b_v_reg;
    logic [SQW-1:0] b_sq_reg  [NCOMP];
    word_t          b_mag_reg [NCOMP];
    logic [NCOMP-1:0] b_sgn_reg;
    // sqrt chain, index 0 is the sum stage
    logic             s_v_reg    [SQ_STEPS+1];
    logic [SQW-1:0]   s_sum_reg  [SQ_STEPS+1];
    logic [REM_W-1:0] s_rem_reg  [SQ_STEPS+1];
    logic [REM_W-1:0] s_rem_next [SQ_STEPS+1];
    word_t            s_root_reg [SQ_STEPS+1];
    word_t            s_root_next[SQ_STEPS+1];
    word_t            s_mag_reg  [SQ_STEPS+1][NCOMP];
    logic [NCOMP-1:0] s_sgn_reg  [SQ_STEPS+1];
    // divider chain, index 0 is the decision stage
    logic             d_v_reg    [Q_BITS+1];
    logic             d_fb_reg   [Q_BITS+1];
    word_t            d_len_reg  [Q_BITS+1];
    logic [NCOMP-1:0] d_sgn_reg  [Q_BITS+1];
    logic [NCOMP-1:0] d_b0_reg   [Q_BITS+1];
    word_t            d_rem_reg  [Q_BITS+1][NCOMP];
    word_t            d_rem_next [Q_BITS+1][NCOMP];
    logic [Q_BITS-1:0] d_q_reg   [Q_BITS+1][NCOMP];
    logic [Q_BITS-1:0] d_q_next  [Q_BITS+1][NCOMP];
    // output
    logic  o_v_reg;
    word_t o_x_reg, o_y_reg, o_z_reg, o_len_reg;
    logic  o_fb_reg;

    assign adv      = !o_v_reg || out_ready;
    assign in_ready = adv;

    word_t in_raw [NCOMP];
    assign in_raw[0] = vec_x;
    assign in_raw[1] = vec_y;
    assign in_raw[2] = vec_z;

    always_comb
    begin
        logic [REM_W+1:0] rs;
        logic [REM_W+1:0] tr;
        logic [DW:0]      t;
        s_rem_next[0]  = '0;
        s_root_next[0] = '0;
        for (int k = 1; k <= SQ_STEPS; k++)
        begin
            rs = {s_rem_reg[k-1], s_sum_reg[k-1][SQW-2*k+1 -: 2]};
            tr = {2'b00, s_root_reg[k-1], 2'b01};
            if (rs >= tr)
            begin
                s_rem_next[k]  = REM_W'(rs - tr);
                s_root_next[k] = {s_root_reg[k-1][DW-2:0], 1'b1};
            end
            else
            begin
                s_rem_next[k]  = REM_W'(rs);
                s_root_next[k] = {s_root_reg[k-1][DW-2:0], 1'b0};
            end
        end
        for (int c = 0; c < NCOMP; c++)
        begin
            d_rem_next[0][c] = '0;
            d_q_next[0][c]   = '0;
        end
        for (int j = 1; j <= Q_BITS; j++)
        begin
            for (int c = 0; c < NCOMP; c++)
            begin
                t = {d_rem_reg[j-1][c], (j == 1) ? d_b0_reg[j-1][c] : 1'b0};
                if (t >= {1'b0, d_len_reg[j-1]})
                begin
                    d_rem_next[j][c] = DW'(t - {1'b0, d_len_reg[j-1]});
                    d_q_next[j][c]   = {d_q_reg[j-1][c][Q_BITS-2:0], 1'b1};
                end
                else
                begin
                    d_rem_next[j][c] = DW'(t);
                    d_q_next[j][c]   = {d_q_reg[j-1][c][Q_BITS-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
            for (int k = 0; k <= SQ_STEPS; k++)
                s_v_reg[k] <= 1'b0;
            for (int j = 0; j <= Q_BITS; j++)
                d_v_reg[j] <= 1'b0;
        end
        else if (adv)
        begin
            a_v_reg    <= in_valid;
            b_v_reg    <= a_v_reg;
            s_v_reg[0] <= b_v_reg;
            for (int k = 1; k <= SQ_STEPS; k++)
                s_v_reg[k] <= s_v_reg[k-1];
            d_v_reg[0] <= s_v_reg[SQ_STEPS];
            for (int j = 1; j <= Q_BITS; j++)
                d_v_reg[j] <= d_v_reg[j-1];
            o_v_reg <= d_v_reg[Q_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < NCOMP; c++)
            begin
                a_mag_reg[c] <= in_raw[c][DW-1] ? DW'(-in_raw[c]) : in_raw[c];
                a_sgn_reg[c] <= in_raw[c][DW-1];
                b_sq_reg[c]  <= {32'd0, a_mag_reg[c]} * {32'd0, a_mag_reg[c]};
                b_mag_reg[c] <= a_mag_reg[c];
                s_mag_reg[0][c] <= b_mag_reg[c];
            end
            b_sgn_reg     <= a_sgn_reg;
            s_sum_reg[0]  <= b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];
            s_rem_reg[0]  <= s_rem_next[0];
            s_root_reg[0] <= s_root_next[0];
            s_sgn_reg[0]  <= b_sgn_reg;
            for (int k = 1; k <= SQ_STEPS; k++)
            begin
                s_sum_reg[k]  <= s_sum_reg[k-1];
                s_rem_reg[k]  <= s_rem_next[k];
                s_root_reg[k] <= s_root_next[k];
                s_sgn_reg[k]  <= s_sgn_reg[k-1];
                for (int c = 0; c < NCOMP; c++)
                    s_mag_reg[k][c] <= s_mag_reg[k-1][c];
            end
            d_len_reg[0] <= s_root_reg[SQ_STEPS];
            d_fb_reg[0]  <= (s_root_reg[SQ_STEPS] <= tol_reg);
            d_sgn_reg[0] <= s_sgn_reg[SQ_STEPS];
            for (int c = 0; c < NCOMP; c++)
            begin
                d_rem_reg[0][c] <= {1'b0, s_mag_reg[SQ_STEPS][c][DW-1:1]};
                d_b0_reg[0][c]  <= s_mag_reg[SQ_STEPS][c][0];
                d_q_reg[0][c]   <= d_q_next[0][c];
            end
            for (int j = 1; j <= Q_BITS; j++)
            begin
                d_len_reg[j] <= d_len_reg[j-1];
                d_fb_reg[j]  <= d_fb_reg[j-1];
                d_sgn_reg[j] <= d_sgn_reg[j-1];
                d_b0_reg[j]  <= d_b0_reg[j-1];
                for (int c = 0; c < NCOMP; c++)
                begin
                    d_rem_reg[j][c] <= d_rem_next[j][c];
                    d_q_reg[j][c]   <= d_q_next[j][c];
                end
            end
            o_len_reg <= d_len_reg[Q_BITS];
            o_fb_reg  <= d_fb_reg[Q_BITS];
            if (d_fb_reg[Q_BITS])
            begin
                o_x_reg <= fbx_reg;
                o_y_reg <= fby_reg;
                o_z_reg <= fbz_reg;
            end
            else
            begin
                o_x_reg <= d_sgn_reg[Q_BITS][0] ? DW'(-{15'd0, d_q_reg[Q_BITS][0]})
                                                : {15'd0, d_q_reg[Q_BITS][0]};
                o_y_reg <= d_sgn_reg[Q_BITS][1] ? DW'(-{15'd0, d_q_reg[Q_BITS][1]})
                                                : {15'd0, d_q_reg[Q_BITS][1]};
                o_z_reg <= d_sgn_reg[Q_BITS][2] ? DW'(-{15'd0, d_q_reg[Q_BITS][2]})
                                                : {15'd0, d_q_reg[Q_BITS][2]};
            end
        end
    end

    assign out_valid     = o_v_reg;
    assign unit_x        = o_x_reg;
    assign unit_y        = o_y_reg;
    assign unit_z        = o_z_reg;
    assign vector_length = o_len_reg;
    assign used_fallback = o_fb_reg;

endmodule

// ===== tb/tb_vector3_normalize_with_fallback.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector3_normalize_with_fallback
// Drives Q16.16 vectors through the normalizer under random stalls. For each
// accepted request it computes the expected unit vector, length and fallback
// flag, and compares each returned result, in order, field by field.
// ----------------------------------------------------------------------------
module tb_vector3_normalize_with_fallback;
    import vnf_pkg::*;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } vec_req_t;

    typedef struct packed {
        logic [31:0] ux;
        logic [31:0] uy;
        logic [31:0] uz;
        logic [31:0] len;
        logic        fb;
    } norm_res_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic signed [31:0] vec_x, vec_y, vec_z;
    logic        out_valid;
    logic        out_ready;
    logic signed [31:0] unit_x, unit_y, unit_z;
    logic [31:0] vector_length;
    logic        used_fallback;

    vector3_normalize_with_fallback dut (.*);

    logic [31:0] tol_reg, fbx_reg, fby_reg, fbz_reg;
    vec_req_t    pending_reqs[$];
    norm_res_t   expected_norms[$];
    int          mismatches = 0;
    int          src_idle_pct = 0;
    int          dst_idle_pct = 0;
    bit          src_hold = 0;
    logic        in_fire;

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] abs32(logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [31:0] root64(logic [63:0] s);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r[31:0];
    endfunction

    function automatic logic [31:0] scale_comp(logic [31:0] c, logic [31:0] len);
        logic [63:0] q;
        q = ({32'd0, abs32(c)} << 16) / {32'd0, len};
        if (c[31]) q = ~q + 64'd1;
        return q[31:0];
    endfunction

    function automatic norm_res_t normalize_vec(vec_req_t v);
        norm_res_t   r;
        logic [63:0] ax, ay, az;
        ax = abs32(v.x);
        ay = abs32(v.y);
        az = abs32(v.z);
        r.len = root64(ax * ax + ay * ay + az * az);
        if (r.len <= tol_reg) begin
            r.ux = fbx_reg;
            r.uy = fby_reg;
            r.uz = fbz_reg;
            r.fb = 1'b1;
        end
        else begin
            r.ux = scale_comp(v.x, r.len);
            r.uy = scale_comp(v.y, r.len);
            r.uz = scale_comp(v.z, r.len);
            r.fb = 1'b0;
        end
        return r;
    endfunction

    // request taken at the last rising edge
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            in_fire <= 1'b0;
        else
            in_fire <= in_valid && in_ready;
    end

    // driver
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_fire) begin
            if (pending_reqs.size() != 0 && !src_hold &&
                $urandom_range(99, 0) >= src_idle_pct) begin
                in_valid <= 1'b1;
                {vec_x, vec_y, vec_z} <= pending_reqs.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= ($urandom_range(99, 0) >= dst_idle_pct);
    end

    // monitor
    always @(posedge clk) begin
        norm_res_t e;
        if (rst_n && in_valid && in_ready)
            expected_norms.push_back(normalize_vec({vec_x, vec_y, vec_z}));
        if (rst_n && out_valid && out_ready) begin
            if (expected_norms.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
            end
            else begin
                e = expected_norms.pop_front();
                if ({unit_x, unit_y, unit_z, vector_length, used_fallback} !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h %h %h %h %b got %h %h %h %h %b",
                                 e.ux, e.uy, e.uz, e.len, e.fb,
                                 unit_x, unit_y, unit_z, vector_length, used_fallback);
                end
            end
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_TOLERANCE:  tol_reg = val;
            CFG_FALLBACK_X: fbx_reg = val;
            CFG_FALLBACK_Y: fby_reg = val;
            default:        fbz_reg = val;
        endcase
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || in_valid || expected_norms.size() != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    task automatic push_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        pending_reqs.push_back({x, y, z});
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(5, 0))
            0: return $urandom_range(255, 0) - 128;
            1: return $urandom_range(32'h0002_0000, 0) - 32'h0001_0000;
            2: return $urandom_range(3, 0) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return $urandom();
        endcase
    endfunction

    task automatic run_random(int n, logic [31:0] tol);
        write_reg(CFG_TOLERANCE, tol);
        write_reg(CFG_FALLBACK_X, $urandom());
        write_reg(CFG_FALLBACK_Y, $urandom());
        write_reg(CFG_FALLBACK_Z, $urandom());
        repeat (n) push_vec(rand_comp(), rand_comp(), rand_comp());
        drain();
    endtask

    initial begin
        rst_n = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_data = 0;
        in_valid = 0;
        out_ready = 0;
        vec_x = 0;
        vec_y = 0;
        vec_z = 0;
        tol_reg = 0;
        fbx_reg = 0;
        fby_reg = 0;
        fbz_reg = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // reset config: zero vector falls back to zeros
        push_vec(0, 0, 0);
        push_vec(32'h0001_0000, 0, 0);
        push_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        push_vec(32'h8000_0000, 0, 32'h7fff_ffff);
        push_vec(32'hffff_ffff, 1, 0);
        push_vec(0, 0, 1);
        push_vec(32'hffff_0000, 32'h0001_0000, 32'hffff_0000);
        drain();

        write_reg(CFG_TOLERANCE, 32'h0001_0000);
        write_reg(CFG_FALLBACK_X, 32'h8000_0000);
        write_reg(CFG_FALLBACK_Y, 32'h7fff_ffff);
        write_reg(CFG_FALLBACK_Z, 32'h0001_0000);
        push_vec(32'h0001_0000, 0, 0);
        push_vec(32'h0001_0001, 0, 0);
        push_vec(0, 0, 0);
        push_vec(32'h0000_ffff, 0, 0);
        push_vec(32'h0000_b505, 32'h0000_b505, 0);
        drain();

        write_reg(CFG_TOLERANCE, 32'hffff_ffff);
        push_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_vec(32'h1234_5678, 32'h8765_4321, 32'h0);
        drain();

        src_idle_pct = 17;
        dst_idle_pct = 55;
        run_random(300, 0);
        run_random(250, $urandom_range(32'h0004_0000, 0));

        // hold off the sender while the requests queue up, then release it
        src_hold = 1;
        repeat (40) push_vec(rand_comp(), rand_comp(), rand_comp());
        repeat (20) @(posedge clk);
        src_hold = 0;
        drain();

        src_idle_pct = 55;
        dst_idle_pct = 17;
        run_random(400, $urandom());
        run_random(150, 32'h7fff_ffff);

        src_idle_pct = 0;
        dst_idle_pct = 0;
        run_random(550, $urandom_range(32'h0100_0000, 0));

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
design/vnf_pkg.sv
design/vector3_normalize_with_fallback.sv
tb/tb_vector3_normalize_with_fallback.sv
